FILE: sv/iirl_pkg.sv
package iirl_pkg;

	// fixed field widths
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned COUNT_W = 7;

	// request codes
	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // latch request, check range
		logic rd_pos;   // read entry at latched position
		logic shift;    // move one entry per cycle
		logic commit;   // final write, count update, result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_ok;      // request at the ports passes its checks
		op_t  op;          // request code at the ports
		logic shift_done;  // no reads left and no write pending
	} sts_t;

endpackage

FILE: sv/iirl_ram.sv
module iirl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/iirl_ctrl.sv
module iirl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  iirl_pkg::sts_t    sts,
	output logic              busy,
	output iirl_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_COMMIT
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!sts.req_ok) begin
							state_q <= S_COMMIT;
						end else begin
							case (sts.op)
								iirl_pkg::OP_READ:  state_q <= S_READ;
								iirl_pkg::OP_WRITE: state_q <= S_COMMIT;
								default:            state_q <= S_SHIFT;
							endcase
						end
					end
				end
				S_READ:   state_q <= S_COMMIT;
				S_SHIFT: begin
					if (sts.shift_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = start && (state_q == S_IDLE);
		cmd.rd_pos = (state_q == S_READ);
		cmd.shift  = (state_q == S_SHIFT);
		cmd.commit = (state_q == S_COMMIT);
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: sv/iirl_dp.sv
module iirl_dp #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iirl_pkg::cmd_t                cmd,
	input  logic [1:0]                    operation,
	input  logic [iirl_pkg::POS_W-1:0]    position,
	input  logic signed [iirl_pkg::DATA_W-1:0] value,
	output iirl_pkg::sts_t                sts,
	output logic                          done,
	output logic signed [iirl_pkg::DATA_W-1:0] read_value,
	output logic [iirl_pkg::COUNT_W-1:0]  entry_count,
	output logic [1:0]                    status
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned WW = (CW > iirl_pkg::POS_W) ? CW : iirl_pkg::POS_W;

	iirl_pkg::op_t     op_in;
	iirl_pkg::op_t     op_q;
	iirl_pkg::status_t chk_st;
	iirl_pkg::status_t st_q;
	iirl_pkg::status_t st_out_q;

	logic [AW-1:0] pos_q;
	logic [iirl_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nxt;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] pos_c;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] wadr_q;
	logic [CW-1:0] rem_q;
	logic          pend_q;
	logic          done_q;
	logic [iirl_pkg::DATA_W-1:0] rv_q;
	logic [iirl_pkg::COUNT_W-1:0] ec_q;
	logic [WW-1:0] pos_w;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] nxt_w;
	logic          full;
	logic          ok_q;
	logic          is_ins;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [iirl_pkg::DATA_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [iirl_pkg::DATA_W-1:0] ram_rdata;

	// range and full checks on the request at the ports
	assign op_in = iirl_pkg::op_t'(operation);
	assign pos_w = WW'(position);
	assign cnt_w = WW'(cnt_q);
	assign pos_c = pos_w[CW-1:0];
	assign full  = (cnt_q == CW'(CAPACITY));

	always_comb begin
		case (op_in)
			iirl_pkg::OP_INSERT: begin
				if (pos_w > cnt_w) begin
					chk_st = iirl_pkg::ST_RANGE;
				end else if (full) begin
					chk_st = iirl_pkg::ST_FULL;
				end else begin
					chk_st = iirl_pkg::ST_OK;
				end
			end
			default: begin
				if (pos_w >= cnt_w) begin
					chk_st = iirl_pkg::ST_RANGE;
				end else begin
					chk_st = iirl_pkg::ST_OK;
				end
			end
		endcase
	end

	assign ok_q   = (st_q == iirl_pkg::ST_OK);
	assign is_ins = (op_q == iirl_pkg::OP_INSERT);

	// count after the request
	assign cnt_dec = cnt_q - CW'(1);
	always_comb begin
		cnt_nxt = cnt_q;
		if (ok_q && is_ins) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (ok_q && (op_q == iirl_pkg::OP_REMOVE)) begin
			cnt_nxt = cnt_dec;
		end
	end
	assign nxt_w = WW'(cnt_nxt);

	// request latch and shift cursors
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_in;
			pos_q <= pos_w[AW-1:0];
			val_q <= value;
			st_q  <= chk_st;
			if (op_in == iirl_pkg::OP_INSERT) begin
				rem_q <= cnt_q - pos_c;
				cur_q <= cnt_q[AW-1:0] - AW'(1);
			end else begin
				rem_q <= cnt_q - pos_c - CW'(1);
				cur_q <= pos_w[AW-1:0] + AW'(1);
			end
		end else if (cmd.shift && (rem_q != '0)) begin
			rem_q <= rem_q - CW'(1);
			if (is_ins) begin
				wadr_q <= cur_q + AW'(1);
				cur_q  <= cur_q - AW'(1);
			end else begin
				wadr_q <= cur_q - AW'(1);
				cur_q  <= cur_q + AW'(1);
			end
		end
	end

	// control registers: pending shift write, count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pend_q <= 1'b0;
			end else if (cmd.shift) begin
				pend_q <= (rem_q != '0);
			end
			if (cmd.commit) begin
				cnt_q <= cnt_nxt;
			end
			done_q <= cmd.commit;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rv_q <= (ok_q && (op_q == iirl_pkg::OP_READ)) ? ram_rdata : '0;
			ec_q <= nxt_w[iirl_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			st_out_q <= st_q;
		end
	end

	// memory port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wadr_q;
		ram_wdata = ram_rdata;
		if (cmd.shift && pend_q) begin
			ram_we = 1'b1;
		end else if (cmd.commit && ok_q) begin
			case (op_q)
				iirl_pkg::OP_WRITE, iirl_pkg::OP_INSERT: begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = val_q;
				end
				iirl_pkg::OP_REMOVE: begin
					ram_we    = 1'b1;
					ram_waddr = cnt_dec[AW-1:0];
					ram_wdata = '0;
				end
				default: ram_we = 1'b0;
			endcase
		end
	end
	assign ram_raddr = cmd.rd_pos ? pos_q : cur_q;

	iirl_ram #(
		.WIDTH(iirl_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// status to controller
	always_comb begin
		sts            = '0;
		sts.req_ok     = (chk_st == iirl_pkg::ST_OK);
		sts.op         = op_in;
		sts.shift_done = (rem_q == '0) && !pend_q;
	end

	assign done        = done_q;
	assign read_value  = rv_q;
	assign entry_count = ec_q;
	assign status      = st_out_q;

endmodule

FILE: sv/indexed_insert_remove_list_core.sv
// Ordered list of signed 32-bit words with indexed read, write, insert and remove.
// Request channel: operation, position and value are taken at a rising edge where
// start is high and busy is low. busy stays high until the item is finished.
// Result channel: done is high for one cycle with read_value, entry_count and
// status; the receiver takes it in that cycle and cannot hold it off.
// Steps from the accepting edge, done being registered from the commit state:
//   write or any rejected request: commit state only
//   read: read state for the registered memory read, then commit
//   insert or remove: shift state while n entries move, then commit,
//   n = count - position on insert, count - position - 1 on remove
// Entries live in a single-port-write, registered-read RAM; a shift moves one
// entry per cycle through that RAM port pair, which sets the insert/remove time.
// A new item can be accepted in the same cycle as the previous done strobe.
// Reset clears the entry count and the controller; the RAM contents are not
// cleared and no clearing pass is needed since reads only reach written slots.
module indexed_insert_remove_list_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          operation,
	input  logic [iirl_pkg::POS_W-1:0]          position,
	input  logic signed [iirl_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic signed [iirl_pkg::DATA_W-1:0]  read_value,
	output logic [iirl_pkg::COUNT_W-1:0]        entry_count,
	output logic [1:0]                          status
);

	iirl_pkg::cmd_t cmd;
	iirl_pkg::sts_t sts;

	// sequencer
	iirl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	// storage, cursors and result registers
	iirl_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (operation),
		.position   (position),
		.value      (value),
		.sts        (sts),
		.done       (done),
		.read_value (read_value),
		.entry_count(entry_count),
		.status     (status)
	);

endmodule

FILE: tb/sv/iirl_list_checker.sv
`timescale 1ns / 100ps

module iirl_list_checker #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          operation,
	input  logic [iirl_pkg::POS_W-1:0]          position,
	input  logic signed [iirl_pkg::DATA_W-1:0]  value,
	input  logic                                done,
	input  logic signed [iirl_pkg::DATA_W-1:0]  read_value,
	input  logic [iirl_pkg::COUNT_W-1:0]        entry_count,
	input  logic [1:0]                          status,
	output int                                  mismatches,
	output int                                  outstanding
);

	// one predicted result per item
	typedef struct packed {
		logic signed [iirl_pkg::DATA_W-1:0] rd;
		logic [iirl_pkg::COUNT_W-1:0]       cnt;
		iirl_pkg::status_t                  st;
	} list_result_t;

	// shadow copy of the list
	logic signed [iirl_pkg::DATA_W-1:0] slots [CAPACITY];
	int unsigned                        used;
	list_result_t                       results_q [$];
	int                                 fail_tally;

	// apply one item to the shadow list and return its result
	function automatic list_result_t apply_request(iirl_pkg::op_t op, int unsigned pos,
			logic signed [iirl_pkg::DATA_W-1:0] word);
		list_result_t res;
		res.rd = '0;
		res.st = iirl_pkg::ST_OK;
		case (op)
			iirl_pkg::OP_READ: begin
				if (pos >= used || pos >= CAPACITY)
					res.st = iirl_pkg::ST_RANGE;
				else
					res.rd = slots[pos];
			end
			iirl_pkg::OP_WRITE: begin
				if (pos >= used || pos >= CAPACITY)
					res.st = iirl_pkg::ST_RANGE;
				else
					slots[pos] = word;
			end
			iirl_pkg::OP_INSERT: begin
				// range check takes priority over the full check
				if (pos > used) begin
					res.st = iirl_pkg::ST_RANGE;
				end else if (used >= CAPACITY) begin
					res.st = iirl_pkg::ST_FULL;
				end else begin
					for (int unsigned j = used; j > pos; j--)
						slots[j] = slots[j - 1];
					slots[pos] = word;
					used++;
				end
			end
			default: begin
				if (pos >= used || pos >= CAPACITY) begin
					res.st = iirl_pkg::ST_RANGE;
				end else begin
					for (int unsigned j = pos; j + 1 < used; j++)
						slots[j] = slots[j + 1];
					slots[used - 1] = '0;
					used--;
				end
			end
		endcase
		res.cnt = used[iirl_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// compare each done strobe with the oldest prediction, then predict new items
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			used = 0;
			results_q.delete();
			fail_tally = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (results_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_tally++;
				end else begin
					want = results_q.pop_front();
					if (read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", want.rd, read_value);
						fail_tally++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
						fail_tally++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_tally++;
					end
				end
			end
			if (start && !busy)
				results_q.push_back(apply_request(iirl_pkg::op_t'(operation), position,
					value));
			mismatches <= fail_tally;
			outstanding <= results_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_indexed_insert_remove_list_core.sv
`timescale 1ns / 100ps

module tb_indexed_insert_remove_list_core;

	localparam int unsigned CAPACITY     = 64;
	localparam int unsigned ITEM_TOTAL   = 1550;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 70;

	// random walk of the list length
	typedef enum logic [1:0] {
		GROW,
		SHRINK,
		CHURN
	} walk_t;

	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                start       = 1'b0;
	logic [1:0]                          operation   = iirl_pkg::OP_READ;
	logic [iirl_pkg::POS_W-1:0]          position    = '0;
	logic signed [iirl_pkg::DATA_W-1:0]  value       = '0;
	logic                                busy;
	logic                                done;
	logic signed [iirl_pkg::DATA_W-1:0]  read_value;
	logic [iirl_pkg::COUNT_W-1:0]        entry_count;
	logic [1:0]                          status;
	int                                  mismatches;
	int                                  outstanding;

	int unsigned                         list_len    = 0;
	int unsigned                         sent        = 0;
	int unsigned                         idle_cycles = 0;

	indexed_insert_remove_list_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.value(value),
		.done(done),
		.read_value(read_value),
		.entry_count(entry_count),
		.status(status)
	);

	iirl_list_checker #(
		.CAPACITY(CAPACITY)
	) list_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.value(value),
		.done(done),
		.read_value(read_value),
		.entry_count(entry_count),
		.status(status),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog on cycles with no item and no result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// present one item and hold it until accepted
	task automatic send_item(input iirl_pkg::op_t op, input int unsigned pos,
			input logic [iirl_pkg::DATA_W-1:0] word);
		operation <= op;
		position  <= pos[iirl_pkg::POS_W-1:0];
		value     <= word;
		start     <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
		// length bookkeeping for position choice only
		if (op == iirl_pkg::OP_INSERT && pos <= list_len && list_len < CAPACITY)
			list_len++;
		else if (op == iirl_pkg::OP_REMOVE && pos < list_len)
			list_len--;
	endtask

	// sender gap
	task automatic hold_off(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// stop sending until every result is back
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// extremes now and then, otherwise any word
	function automatic logic [iirl_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// operation mix follows the walk direction
	function automatic iirl_pkg::op_t pick_op(walk_t mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mode)
			GROW:    return (r < 60) ? iirl_pkg::OP_INSERT :
				(r < 70) ? iirl_pkg::OP_REMOVE :
				(r < 85) ? iirl_pkg::OP_READ : iirl_pkg::OP_WRITE;
			SHRINK:  return (r < 60) ? iirl_pkg::OP_REMOVE :
				(r < 70) ? iirl_pkg::OP_INSERT :
				(r < 85) ? iirl_pkg::OP_READ : iirl_pkg::OP_WRITE;
			default: return iirl_pkg::op_t'(r[1:0]);
		endcase
	endfunction

	// mostly legal positions, biased to the ends, some anywhere from 0 to CAPACITY
	function automatic int unsigned pick_position(iirl_pkg::op_t op);
		int unsigned r;
		int unsigned top;
		r = $urandom_range(0, 99);
		if (r < 12 || (op != iirl_pkg::OP_INSERT && list_len == 0))
			return $urandom_range(0, CAPACITY);
		top = (op == iirl_pkg::OP_INSERT) ? list_len : list_len - 1;
		if (r < 20)
			return 0;
		if (r < 28)
			return top;
		return $urandom_range(0, top);
	endfunction

	initial begin
		walk_t         mode;
		iirl_pkg::op_t op;
		int unsigned   full_hits;
		int unsigned   churn_left;
		bit            steady;

		mode       = GROW;
		full_hits  = 0;
		churn_left = 0;
		steady     = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every access out of range, insert past the end
		send_item(iirl_pkg::OP_READ, 0, '0);
		send_item(iirl_pkg::OP_REMOVE, 0, '0);
		send_item(iirl_pkg::OP_WRITE, 0, '1);
		send_item(iirl_pkg::OP_INSERT, 1, 32'h1234_5678);
		// build a short list with extreme words at front, middle and end
		send_item(iirl_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
		send_item(iirl_pkg::OP_INSERT, 1, 32'h8000_0000);
		send_item(iirl_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		send_item(iirl_pkg::OP_INSERT, 3, 32'h0000_0000);
		send_item(iirl_pkg::OP_INSERT, 5, 32'h0000_0001);
		send_item(iirl_pkg::OP_READ, 0, '0);
		send_item(iirl_pkg::OP_READ, 1, '0);
		send_item(iirl_pkg::OP_READ, 2, '0);
		send_item(iirl_pkg::OP_READ, 3, '0);
		send_item(iirl_pkg::OP_READ, 4, '0);
		send_item(iirl_pkg::OP_WRITE, 3, 32'h5555_5555);
		send_item(iirl_pkg::OP_WRITE, 4, 32'hAAAA_AAAA);
		send_item(iirl_pkg::OP_READ, 3, '0);
		// remove at the front, at the tail, and past the end
		send_item(iirl_pkg::OP_REMOVE, 0, 32'hDEAD_BEEF);
		send_item(iirl_pkg::OP_REMOVE, 2, '0);
		send_item(iirl_pkg::OP_REMOVE, 2, '0);
		send_item(iirl_pkg::OP_READ, 1, '0);
		send_item(iirl_pkg::OP_INSERT, CAPACITY, 32'hFFFF_0000);
		settle();

		// random walk: fill to full, drain to empty, churn in between
		while (sent < ITEM_TOTAL) begin
			if (sent % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			op = pick_op(mode);
			send_item(op, pick_position(op), pick_word());
			if (!steady)
				hold_off($urandom_range(0, 7));
			case (mode)
				GROW: begin
					if (list_len == CAPACITY) begin
						full_hits++;
						if (full_hits > 4) begin
							send_item(iirl_pkg::OP_INSERT, CAPACITY, pick_word());
							full_hits = 0;
							mode = SHRINK;
							settle();
						end
					end
				end
				SHRINK: begin
					if (list_len == 0) begin
						churn_left = $urandom_range(40, 120);
						mode = CHURN;
						settle();
					end
				end
				default: begin
					if (churn_left == 0) begin
						mode = GROW;
						settle();
					end else begin
						churn_left--;
					end
				end
			endcase
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
sv/iirl_pkg.sv
sv/iirl_ram.sv
sv/iirl_ctrl.sv
sv/iirl_dp.sv
sv/indexed_insert_remove_list_core.sv
tb/sv/iirl_list_checker.sv
tb/sv/tb_indexed_insert_remove_list_core.sv
